### rtl/tmsf_pkg.sv
// tmsf_pkg: types and constants shared by the trimmed mean sample filter
// depends on nothing; imported by trimmed_mean_sample_filter_top and its bench
`timescale 1ns / 1ps

package tmsf_pkg;

  localparam int WINDOW   = 16;
  localparam int CHANNELS = 16;

  localparam int CHAN_W   = 4;
  localparam int SAMPLE_W = 16;
  localparam int TS_W     = 4;
  localparam int TE_W     = 5;
  localparam int DV_W     = 5;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam int IDX_W  = $clog2(WINDOW);
  localparam int CNT_W  = $clog2(WINDOW + 1);
  localparam int CMP_W  = (CNT_W > TE_W) ? CNT_W : TE_W;
  localparam int SUM_W  = SAMPLE_W + $clog2(WINDOW);
  localparam int STEP_W = $clog2(SUM_W);

  localparam logic [CFG_IDX_W-1:0] REG_TRIM_START  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIM_END    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_DIVISOR = 2'd2;

  localparam logic [TS_W-1:0] TRIM_START_RST  = 4'd4;
  localparam logic [TE_W-1:0] TRIM_END_RST    = 5'd12;
  localparam logic [DV_W-1:0] AVG_DIVISOR_RST = 5'd8;

  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = {SAMPLE_W{1'b1}};

  typedef struct packed {
    logic [CHAN_W-1:0]   channel;
    logic [SAMPLE_W-1:0] sample;
  } in_item_t;

  typedef struct packed {
    logic [CHAN_W-1:0]   result_channel;
    logic [SAMPLE_W-1:0] average;
  } out_item_t;

endpackage

### rtl/trimmed_mean_sample_filter_top.sv
// a sample that does not complete the window is stored and busy stays low; the sample
// completing the window raises busy for 16 rank passes (each a scan on one shared
// comparator), then 20 steps of a bit-serial divider; out_valid pulses one cycle,
// in the cycle that busy drops; the receiver cannot stall
// reset (rst_n, synchronous): window empty, registers at 4 / 12 / 8, no result pending
`timescale 1ns / 1ps

module trimmed_mean_sample_filter_top import tmsf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_data,
  output logic                 out_valid,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RANK  = 5'b00010,
    S_DRAIN = 5'b00100,
    S_ACC   = 5'b01000,
    S_DIV   = 5'b10000
  } state_t;

  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(WINDOW - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SUM_W - 1);

  state_t state_r, state_nxt;

  logic [TS_W-1:0] trim_start_r;
  logic [TE_W-1:0] trim_end_r;
  logic [DV_W-1:0] avg_div_r;

  logic [IDX_W-1:0] fill_r, fill_nxt;
  logic [IDX_W-1:0] i_r, i_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] rank_r, rank_nxt;
  logic             cmp_v_r, cmp_v_nxt;
  logic [IDX_W-1:0] cmp_j_r, cmp_j_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [SUM_W-1:0] quot_r, quot_nxt;
  logic [DV_W-1:0]  rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [CHAN_W-1:0] chan_r, chan_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, out_data_nxt;

  logic [SAMPLE_W-1:0] sample_mem [WINDOW];
  logic [SAMPLE_W-1:0] rd_a_r, rd_b_r;

  logic              accept;
  logic              cmp_hit;
  logic [CMP_W-1:0]  lo_c, hi_c, rank_c;
  logic              in_range;
  logic              range_empty;
  logic [SUM_W-1:0]  sum_add;
  logic [DV_W:0]     rem_sh;
  logic              div_ge;
  logic [DV_W:0]     rem_sub;
  logic [DV_W-1:0]   rem_new;
  logic [SUM_W-1:0]  quot_new;
  logic [SAMPLE_W-1:0] avg_val;

  assign busy      = (state_r != S_IDLE);
  assign accept    = start && !busy;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // stable rank: smaller values, or equal values at a lower slot, come first
  assign cmp_hit = (rd_b_r < rd_a_r) || ((rd_b_r == rd_a_r) && (cmp_j_r < i_r));

  assign lo_c   = CMP_W'(trim_start_r);
  assign hi_c   = (CMP_W'(trim_end_r) > CMP_W'(WINDOW)) ? CMP_W'(WINDOW) : CMP_W'(trim_end_r);
  assign rank_c = CMP_W'(rank_r);
  assign range_empty = (lo_c >= hi_c);
  assign in_range    = (rank_c >= lo_c) && (rank_c < hi_c);
  assign sum_add     = in_range ? (sum_r + SUM_W'(rd_a_r)) : sum_r;

  // restoring divider, one quotient bit per cycle
  assign rem_sh   = {rem_r, quot_r[SUM_W-1]};
  assign div_ge   = (rem_sh >= {1'b0, avg_div_r});
  assign rem_sub  = rem_sh - {1'b0, avg_div_r};
  assign rem_new  = div_ge ? rem_sub[DV_W-1:0] : rem_sh[DV_W-1:0];
  assign quot_new = {quot_r[SUM_W-2:0], div_ge};

  always_comb begin
    if (range_empty) begin
      avg_val = '0;
    end else if (avg_div_r == '0) begin
      avg_val = SAMPLE_MAX;
    end else if (quot_new > SUM_W'(SAMPLE_MAX)) begin
      avg_val = SAMPLE_MAX;
    end else begin
      avg_val = quot_new[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    rank_nxt      = rank_r;
    sum_nxt       = sum_r;
    quot_nxt      = quot_r;
    rem_nxt       = rem_r;
    step_nxt      = step_r;
    chan_nxt      = chan_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    cmp_v_nxt     = (state_r == S_RANK);
    cmp_j_nxt     = j_r;

    if (cmp_v_r && cmp_hit) begin
      rank_nxt = rank_r + IDX_W'(1);
    end

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          chan_nxt = in_data.channel;
          if (fill_r == LAST_IDX) begin
            fill_nxt  = '0;
            state_nxt = S_RANK;
            i_nxt     = '0;
            j_nxt     = '0;
            rank_nxt  = '0;
            sum_nxt   = '0;
          end else begin
            fill_nxt = fill_r + IDX_W'(1);
          end
        end
      end
      S_RANK: begin
        j_nxt = j_r + IDX_W'(1);
        if (j_r == LAST_IDX) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_ACC;
      end
      S_ACC: begin
        sum_nxt  = sum_add;
        rank_nxt = '0;
        j_nxt    = '0;
        if (i_r == LAST_IDX) begin
          state_nxt = S_DIV;
          quot_nxt  = sum_add;
          rem_nxt   = '0;
          step_nxt  = '0;
        end else begin
          i_nxt     = i_r + IDX_W'(1);
          state_nxt = S_RANK;
        end
      end
      S_DIV: begin
        quot_nxt = quot_new;
        rem_nxt  = rem_new;
        step_nxt = step_r + STEP_W'(1);
        if (step_r == LAST_STEP) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
          out_data_nxt.result_channel = chan_r;
          out_data_nxt.average        = avg_val;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      fill_r       <= '0;
      out_valid_r  <= 1'b0;
      cmp_v_r      <= 1'b0;
      trim_start_r <= TRIM_START_RST;
      trim_end_r   <= TRIM_END_RST;
      avg_div_r    <= AVG_DIVISOR_RST;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
      cmp_v_r     <= cmp_v_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_TRIM_START:  trim_start_r <= cfg_wdata[TS_W-1:0];
          REG_TRIM_END:    trim_end_r   <= cfg_wdata[TE_W-1:0];
          REG_AVG_DIVISOR: avg_div_r    <= cfg_wdata[DV_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    i_r        <= i_nxt;
    j_r        <= j_nxt;
    rank_r     <= rank_nxt;
    cmp_j_r    <= cmp_j_nxt;
    sum_r      <= sum_nxt;
    quot_r     <= quot_nxt;
    rem_r      <= rem_nxt;
    step_r     <= step_nxt;
    chan_r     <= chan_nxt;
    out_data_r <= out_data_nxt;
  end

  // window buffer: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_mem[fill_r] <= in_data.sample;
    end
    rd_a_r <= sample_mem[i_r];
    rd_b_r <= sample_mem[j_r];
  end

`ifndef ASSERT_OFF
  a_fill_starts_compute: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (fill_r == LAST_IDX)) |=> busy)
    else $error("window completion did not start the computation");

  a_result_after_div: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(state_r == S_DIV))
    else $error("result strobe without a finished division");

  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held longer than one cycle");

  a_window_restarted: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> (fill_r == '0))
    else $error("window not restarted while computing");
`endif

endmodule

### bench/tb_trimmed_mean_sample_filter_top.sv
// tb_trimmed_mean_sample_filter_top: self-checking bench for the trimmed mean sample filter
// predicts every window average from the accepted samples; depends on tmsf_pkg and the top
`timescale 1ns / 1ps

module tb_trimmed_mean_sample_filter_top import tmsf_pkg::*; ();

  localparam int STALL_LIMIT = 4000;
  localparam int MAX_REPORTS = 10;

  typedef enum int {
    PAT_UNIFORM,
    PAT_LOW,
    PAT_HIGH,
    PAT_FLAT,
    PAT_EXTREME
  } sample_pattern_t;

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  in_item_t             in_data;
  logic                 out_valid;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;

  trimmed_mean_sample_filter_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // shadow copy of the filter state
  logic [SAMPLE_W-1:0] window_samples [WINDOW];
  int unsigned         window_fill;
  logic [TS_W-1:0]     shadow_trim_start;
  logic [TE_W-1:0]     shadow_trim_end;
  logic [DV_W-1:0]     shadow_divisor;

  out_item_t pending_averages [$];
  int        fail_count;
  int        stall_cycles;
  int        sender_idle_pct;

  function automatic logic [SAMPLE_W-1:0] trimmed_average();
    logic [SAMPLE_W-1:0] ranked [WINDOW];
    logic [SAMPLE_W-1:0] key;
    int                  lo;
    int                  hi;
    int                  k;
    int                  j;
    logic [31:0]         total;
    logic [31:0]         quotient;
    hi = (shadow_trim_end > WINDOW) ? WINDOW : int'(shadow_trim_end);
    lo = int'(shadow_trim_start);
    if (lo >= hi) return '0;
    if (shadow_divisor == '0) return SAMPLE_MAX;
    for (k = 0; k < WINDOW; k++) ranked[k] = window_samples[k];
    for (k = 1; k < WINDOW; k++) begin
      key = ranked[k];
      j = k;
      while (j > 0 && ranked[j-1] > key) begin
        ranked[j] = ranked[j-1];
        j--;
      end
      ranked[j] = key;
    end
    total = '0;
    for (k = lo; k < hi; k++) total += 32'(ranked[k]);
    quotient = total / 32'(shadow_divisor);
    return (quotient > 32'(SAMPLE_MAX)) ? SAMPLE_MAX : quotient[SAMPLE_W-1:0];
  endfunction

  // prediction, result checking and watchdog, all on the rising edge
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    logic      active;
    active = 1'b0;
    if (!rst_n) begin
      window_fill       = 0;
      shadow_trim_start = TRIM_START_RST;
      shadow_trim_end   = TRIM_END_RST;
      shadow_divisor    = AVG_DIVISOR_RST;
    end else begin
      if (cfg_we) begin
        active = 1'b1;
        case (cfg_index)
          REG_TRIM_START:  shadow_trim_start = cfg_wdata[TS_W-1:0];
          REG_TRIM_END:    shadow_trim_end   = cfg_wdata[TE_W-1:0];
          REG_AVG_DIVISOR: shadow_divisor    = cfg_wdata[DV_W-1:0];
          default: ;
        endcase
      end
      if (start && busy === 1'b0) begin
        active = 1'b1;
        window_samples[window_fill] = in_data.sample;
        window_fill++;
        if (window_fill == WINDOW) begin
          window_fill         = 0;
          want.result_channel = in_data.channel;
          want.average        = trimmed_average();
          pending_averages.push_back(want);
        end
      end
      if (out_valid !== 1'b0) begin
        active = 1'b1;
        if (pending_averages.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected result: channel %0d average %0d",
                     out_data.result_channel, out_data.average);
        end else begin
          want = pending_averages.pop_front();
          if (out_data.result_channel !== want.result_channel ||
              out_data.average !== want.average) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch: channel exp %0d got %0d, average exp %0d got %0d",
                       want.result_channel, out_data.result_channel,
                       want.average, out_data.average);
          end
        end
      end
    end
    stall_cycles = active ? 0 : stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send_sample(input logic [CHAN_W-1:0] chan, input logic [SAMPLE_W-1:0] smp);
    in_item_t item;
    item.channel = chan;
    item.sample  = smp;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy !== 1'b0);
    // sender gap, one negedge per idle cycle
    while ($urandom_range(99) < sender_idle_pct) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  // block idle: no transaction pending, nothing in flight
  task automatic settle_idle();
    @(negedge clk);
    start <= 1'b0;
    while (pending_averages.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic set_filter(input logic [CFG_W-1:0] ts, input logic [CFG_W-1:0] te,
                            input logic [CFG_W-1:0] dv);
    settle_idle();
    write_reg(REG_TRIM_START, ts);
    write_reg(REG_TRIM_END, te);
    write_reg(REG_AVG_DIVISOR, dv);
  endtask

  function automatic logic [SAMPLE_W-1:0] pick_sample(input sample_pattern_t pat,
                                                     input logic [SAMPLE_W-1:0] flat);
    case (pat)
      PAT_LOW:     return SAMPLE_W'($urandom_range(0, 255));
      PAT_HIGH:    return SAMPLE_W'($urandom_range(65000, 65535));
      PAT_FLAT:    return flat;
      PAT_EXTREME: return $urandom_range(1) ? SAMPLE_MAX : '0;
      default:     return SAMPLE_W'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic random_filter();
    logic [CFG_W-1:0] ts;
    logic [CFG_W-1:0] te;
    logic [CFG_W-1:0] dv;
    case ($urandom_range(0, 5))
      0:       ts = '0;
      1:       ts = 5'd15;
      default: ts = CFG_W'($urandom_range(0, 31));
    endcase
    case ($urandom_range(0, 6))
      0:       te = '0;
      1:       te = 5'd16;
      2:       te = 5'd31;
      default: te = CFG_W'($urandom_range(0, 31));
    endcase
    case ($urandom_range(0, 9))
      0:       dv = '0;
      1:       dv = 5'd1;
      2:       dv = 5'd16;
      3:       dv = 5'd31;
      default: dv = CFG_W'($urandom_range(1, 31));
    endcase
    set_filter(ts, te, dv);
  endtask

  task automatic test_reset_config();
    int k;
    sender_idle_pct = 0;
    for (k = 0; k < WINDOW; k++)
      send_sample(CHAN_W'($urandom_range(0, 15)), SAMPLE_W'($urandom_range(0, 65535)));
  endtask

  // full window of maximum samples, mixed channels, quotient overflows
  task automatic test_extremes();
    int k;
    set_filter(5'd0, 5'd16, 5'd1);
    for (k = 0; k < WINDOW; k++) send_sample(CHAN_W'(k), SAMPLE_MAX);
  endtask

  task automatic test_special_cases();
    int k;
    // end past the window and zero divisor
    set_filter(5'd2, 5'd31, 5'd0);
    for (k = 0; k < WINDOW; k++) send_sample(4'd9, SAMPLE_W'(65535 - 4001 * k));
    // empty trim range; unused index must change nothing
    set_filter(5'd15, 5'd3, 5'd31);
    write_reg(REG_AVG_DIVISOR + 2'd1, 5'd31);
    for (k = 0; k < WINDOW; k++) send_sample(4'd0, SAMPLE_W'(k * 3000));
    // upper data bit of the 4-bit register is dropped: start lands on 15
    settle_idle();
    write_reg(REG_TRIM_START, 5'h1F);
    write_reg(REG_TRIM_END, 5'd16);
    for (k = 0; k < WINDOW; k++) send_sample(4'd5, SAMPLE_W'($urandom_range(0, 65535)));
  endtask

  task automatic test_random_windows(input int n_items, input int idle_pct);
    int               sent;
    int               k;
    sample_pattern_t  pat;
    logic [SAMPLE_W-1:0] flat;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) random_filter();
      pat  = sample_pattern_t'($urandom_range(0, 4));
      if ($urandom_range(1)) pat = PAT_UNIFORM;
      flat = SAMPLE_W'($urandom_range(0, 65535));
      for (k = 0; k < WINDOW; k++) begin
        // occasional reconfiguration in the middle of a window
        if ($urandom_range(63) == 0) random_filter();
        send_sample(CHAN_W'($urandom_range(0, 15)), pick_sample(pat, flat));
        sent++;
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    start           = 1'b0;
    in_data         = '0;
    cfg_we          = 1'b0;
    cfg_index       = '0;
    cfg_wdata       = '0;
    fail_count      = 0;
    stall_cycles    = 0;
    sender_idle_pct = 0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_config();
    test_extremes();
    test_special_cases();
    test_random_windows(600, 0);
    test_random_windows(640, 55);
    test_random_windows(600, 19);

    settle_idle();
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending_averages.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
